>>> design/vsvu_pkg.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update package
// Shared payload types and constants for the update core.
// ----------------------------------------------------------------------------
package vsvu_pkg;

  typedef struct packed {
    logic               req_type;
    logic               last_atom;
    logic        [31:0] mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic        [31:0] step_out;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } out_item_t;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture input item
    OP_ACC_DIV,   // start acceleration division for component in comp
    OP_ACC_ADD,   // square and accumulate
    OP_MEAN_DIV,  // start mean-square division
    OP_ERR_SQRT,  // start square root of mean
    OP_STEP_DIV,  // start accuracy*2^48/err division
    OP_STEP_SQRT, // start square root of quotient
    OP_STEP_FIN,  // apply limits, update step
    OP_DV_MUL,    // multiply |f| by vstep
    OP_DV_DIV,    // start dv division
    OP_VEL_UPD,   // form new velocity
    OP_DX_MUL,    // multiply |v'| by step
    OP_POS_UPD,   // form new position
    OP_PASS       // copy atom unchanged
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // divider or root unit still working
    logic req_type;
    logic last_atom;
    logic mass_zero;
    logic err_zero;
  } dp_status_t;

  localparam logic [0:0] CFG_ACCURACY = 1'b0;
  localparam logic [0:0] CFG_MAX_STEP = 1'b1;

endpackage

>>> design/vsvu_datapath.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update datapath
// Holds atom, step and error state; shared serial divider and square root.
// ----------------------------------------------------------------------------
module vsvu_datapath #(
  parameter int CntW = 17,
  parameter int MaxAtoms = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  vsvu_pkg::in_item_t  item,
  input  vsvu_pkg::dp_cmd_t   cmd,
  input  logic [31:0]         accuracy,
  input  logic [31:0]         max_step_size,
  output vsvu_pkg::dp_status_t status,
  output vsvu_pkg::out_item_t result
);
  import vsvu_pkg::*;

  in_item_t    cur;
  logic [31:0] step_size;
  logic [31:0] velocity_interval;
  logic [63:0] error_sum;
  logic [CntW-1:0] atom_counter;
  logic [31:0] err;
  logic [63:0] prod;
  logic        acc_pend;
  logic signed [31:0] vnew [3];
  logic signed [31:0] xnew [3];

  // Shared restoring divider: 80-bit dividend, 64-bit divisor, one bit a cycle.
  logic [79:0] div_q;
  logic [64:0] div_r;
  logic [63:0] div_d;
  logic [6:0]  div_cnt;
  logic        div_busy;
  logic [64:0] div_trial;

  // Shared bit-pair square root over 64 bits, one result bit a cycle.
  logic [63:0] sq_x;
  logic [63:0] sq_r;
  logic [63:0] sq_bit;
  logic        sq_busy;

  logic [31:0] comp_f;
  logic [31:0] comp_v;
  logic [31:0] comp_x;
  logic [31:0] fmag;
  logic [63:0] q_lim;
  logic [31:0] acc_sat;
  logic [64:0] sum_w;
  logic [32:0] nw;
  logic [32:0] old33;
  logic [63:0] mean_den;

  always_comb begin
    case (cmd.comp)
      2'd0: begin comp_f = cur.force_x; comp_v = cur.vel_x; comp_x = cur.pos_x; end
      2'd1: begin comp_f = cur.force_y; comp_v = cur.vel_y; comp_x = cur.pos_y; end
      default: begin comp_f = cur.force_z; comp_v = cur.vel_z; comp_x = cur.pos_z; end
    endcase
    fmag = comp_f[31] ? (~comp_f + 32'd1) : comp_f;
  end

  assign div_trial = {div_r[63:0], div_q[79]} - {1'b0, div_d};
  assign q_lim     = div_q[63:0];
  assign acc_sat   = (q_lim > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_lim[31:0];
  assign sum_w     = {1'b0, error_sum} + {1'b0, prod};
  assign mean_den  = 64'(atom_counter) * 64'd3;
  assign old33     = {1'b0, step_size};

  // Step limits applied to the raw root.
  always_comb begin
    nw = status.err_zero ? 33'h0_FFFF_FFFF : {1'b0, sq_r[31:0]};
    if (step_size != 32'd0 && nw > {old33[31:0], 1'b0}) nw = {old33[31:0], 1'b0};
    if (nw > old33 && ({3'd0, nw} * 36'd5) < ({3'd0, old33} * 36'd6)) nw = old33;
    if (nw > {1'b0, max_step_size}) nw = {1'b0, max_step_size};
  end

  assign status.busy      = div_busy | sq_busy;
  assign status.req_type  = cur.req_type;
  assign status.last_atom = cur.last_atom;
  assign status.mass_zero = (cur.mass == 32'd0);
  assign status.err_zero  = (err == 32'd0);

  always_ff @(posedge clk) begin
    logic [63:0] dvv;
    logic signed [33:0] vs;
    logic [31:0] vmag;
    logic signed [33:0] xs;
    if (rst) begin
      step_size <= '0;
      velocity_interval <= '0;
      error_sum <= '0;
      atom_counter <= '0;
      acc_pend <= 1'b0;
      div_busy <= 1'b0;
      sq_busy <= 1'b0;
    end else begin
      // Divider iteration.
      if (div_busy) begin
        if (!div_trial[64]) begin
          div_r <= div_trial;
          div_q <= {div_q[78:0], 1'b1};
        end else begin
          div_r <= {div_r[63:0], div_q[79]};
          div_q <= {div_q[78:0], 1'b0};
        end
        div_cnt <= div_cnt - 7'd1;
        if (div_cnt == 7'd1) div_busy <= 1'b0;
      end
      // Square root iteration.
      if (sq_busy) begin
        if (sq_x >= sq_r + sq_bit) begin
          sq_x <= sq_x - (sq_r + sq_bit);
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == 64'd1) sq_busy <= 1'b0;
      end
      acc_pend <= (cmd.op == OP_ACC_ADD);
      case (cmd.op)
        OP_LOAD: begin
          cur <= item;
          if (!item.req_type && atom_counter < CntW'(MaxAtoms))
            atom_counter <= atom_counter + CntW'(1);
        end
        OP_ACC_DIV: begin
          div_q <= {32'd0, fmag, 16'd0};
          div_r <= '0;
          div_d <= {32'd0, cur.mass};
          div_cnt <= 7'd80;
          div_busy <= 1'b1;
        end
        OP_ACC_ADD: begin
          prod <= 64'(acc_sat) * 64'(acc_sat);
        end
        OP_MEAN_DIV: begin
          div_q <= {16'd0, error_sum};
          div_r <= '0;
          div_d <= mean_den;
          div_cnt <= 7'd80;
          div_busy <= 1'b1;
        end
        OP_ERR_SQRT: begin
          sq_x <= q_lim;
          sq_r <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          sq_busy <= 1'b1;
        end
        OP_STEP_DIV: begin
          err <= sq_r[31:0];
          div_q <= {accuracy, 48'd0};
          div_r <= '0;
          div_d <= {32'd0, sq_r[31:0]};
          div_cnt <= 7'd80;
          div_busy <= 1'b1;
        end
        OP_STEP_SQRT: begin
          // Quotient at or above 2^64 saturates the step.
          sq_x <= (div_q[79:64] != 16'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : q_lim;
          sq_r <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          sq_busy <= 1'b1;
        end
        OP_STEP_FIN: begin
          velocity_interval <= 32'((nw + old33) >> 1);
          step_size <= nw[31:0];
          error_sum <= '0;
          atom_counter <= '0;
          result <= out_item_t'({1'b0, nw[31:0], 192'd0});
        end
        OP_DV_MUL: begin
          prod <= 64'(fmag) * 64'(velocity_interval);
        end
        OP_DV_DIV: begin
          div_q <= {16'd0, prod};
          div_r <= '0;
          div_d <= {16'd0, cur.mass, 16'd0};
          div_cnt <= 7'd80;
          div_busy <= 1'b1;
        end
        OP_VEL_UPD: begin
          dvv = q_lim;
          if (dvv > 64'h1_0000_0000) dvv = 64'h1_0000_0000;
          vs = comp_f[31] ? (34'(signed'(comp_v)) - signed'({1'b0, dvv[32:0]}))
                          : (34'(signed'(comp_v)) + signed'({1'b0, dvv[32:0]}));
          if (vs > 34'sh7FFF_FFFF) vnew[cmd.comp] <= 32'h7FFF_FFFF;
          else if (vs < -34'sh8000_0000) vnew[cmd.comp] <= 32'h8000_0000;
          else vnew[cmd.comp] <= vs[31:0];
        end
        OP_DX_MUL: begin
          vmag = vnew[cmd.comp][31] ? (~vnew[cmd.comp] + 32'd1) : vnew[cmd.comp];
          prod <= 64'(vmag) * 64'(step_size);
        end
        OP_POS_UPD: begin
          xs = vnew[cmd.comp][31] ? (34'(signed'(comp_x)) - 34'(prod[63:32]))
                                  : (34'(signed'(comp_x)) + 34'(prod[63:32]));
          if (xs > 34'sh7FFF_FFFF) xnew[cmd.comp] <= 32'h7FFF_FFFF;
          else if (xs < -34'sh8000_0000) xnew[cmd.comp] <= 32'h8000_0000;
          else xnew[cmd.comp] <= xs[31:0];
          if (cmd.comp == 2'd2) begin
            result.result_kind <= 1'b1;
            result.step_out <= step_size;
            result.new_vel_x <= vnew[0];
            result.new_vel_y <= vnew[1];
            result.new_vel_z <= vnew[2];
            result.new_pos_x <= xnew[0];
            result.new_pos_y <= xnew[1];
            result.new_pos_z <= xs > 34'sh7FFF_FFFF ? 32'h7FFF_FFFF :
                                xs < -34'sh8000_0000 ? 32'h8000_0000 : xs[31:0];
          end
        end
        OP_PASS: begin
          result.result_kind <= 1'b1;
          result.step_out <= step_size;
          result.new_pos_x <= cur.pos_x;
          result.new_pos_y <= cur.pos_y;
          result.new_pos_z <= cur.pos_z;
          result.new_vel_x <= cur.vel_x;
          result.new_vel_y <= cur.vel_y;
          result.new_vel_z <= cur.vel_z;
        end
        default: begin
        end
      endcase
      // Each registered square is added to the sum in the following cycle.
      if (acc_pend)
        error_sum <= sum_w[64] ? '1 : sum_w[63:0];
    end
  end

endmodule

>>> design/vsvu_ctrl.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update controller
// Sequences the datapath through the measure and advance passes.
// ----------------------------------------------------------------------------
module vsvu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  vsvu_pkg::dp_status_t status,
  output vsvu_pkg::dp_cmd_t    cmd
);
  import vsvu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC_DIV, S_ACC_WAIT, S_ACC_SQ, S_ACC_LAST, S_MEAN, S_ESQRT,
    S_SDIV, S_SSQRT, S_SFIN, S_DV_MUL, S_DV_DIV, S_VEL, S_DX, S_POS, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] comp;
  logic       started;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // Command decode from the current state.
  always_comb begin
    cmd.comp = comp;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE:     if (in_valid && !in_stall) cmd.op = OP_LOAD;
      S_ACC_DIV:  cmd.op = OP_ACC_DIV;
      S_ACC_SQ:   cmd.op = OP_ACC_ADD;
      S_MEAN:     cmd.op = OP_MEAN_DIV;
      S_ESQRT:    if (!status.busy && !started) cmd.op = OP_ERR_SQRT;
      S_SDIV:     if (!status.busy && !started) cmd.op = OP_STEP_DIV;
      S_SSQRT:    if (!status.busy && !started) cmd.op = OP_STEP_SQRT;
      S_SFIN:     if (!status.busy) cmd.op = OP_STEP_FIN;
      S_DV_MUL:   cmd.op = status.mass_zero ? OP_PASS : OP_DV_MUL;
      S_DV_DIV:   cmd.op = OP_DV_DIV;
      S_VEL:      if (!status.busy) cmd.op = OP_VEL_UPD;
      S_DX:       cmd.op = OP_DX_MUL;
      S_POS:      cmd.op = OP_POS_UPD;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      comp <= 2'd0;
      started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          comp <= 2'd0;
          state <= S_ACC_DIV;
        end
        S_ACC_DIV: begin
          if (status.req_type) state <= S_DV_MUL;
          else if (status.mass_zero) state <= status.last_atom ? S_MEAN : S_IDLE;
          else state <= S_ACC_WAIT;
        end
        S_ACC_WAIT: if (!status.busy) state <= S_ACC_SQ;
        S_ACC_SQ: begin
          if (comp == 2'd2) state <= S_ACC_LAST;
          else begin
            comp <= comp + 2'd1;
            state <= S_ACC_DIV;
          end
        end
        S_ACC_LAST: state <= status.last_atom ? S_MEAN : S_IDLE;
        S_MEAN: begin started <= 1'b0; state <= S_ESQRT; end
        S_ESQRT: if (!status.busy) begin
          if (started) begin started <= 1'b0; state <= S_SDIV; end
          else started <= 1'b1;
        end
        // The error register is loaded when the division starts, so it is
        // tested only once the division has finished.
        S_SDIV: if (!status.busy) begin
          if (started) begin
            started <= 1'b0;
            state <= status.err_zero ? S_SFIN : S_SSQRT;
          end else started <= 1'b1;
        end
        S_SSQRT: if (!status.busy) begin
          if (started) begin started <= 1'b0; state <= S_SFIN; end
          else started <= 1'b1;
        end
        S_SFIN: if (!status.busy) state <= S_OUT;
        S_DV_MUL: state <= status.mass_zero ? S_OUT : S_DV_DIV;
        S_DV_DIV: state <= S_VEL;
        S_VEL: if (!status.busy) state <= S_DX;
        S_DX: state <= S_POS;
        S_POS: begin
          if (comp == 2'd2) state <= S_OUT;
          else begin
            comp <= comp + 2'd1;
            state <= S_DV_MUL;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/variable_step_verlet_update_core.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update core
// Two-pass variable time step integrator for a stream of atoms.
// ----------------------------------------------------------------------------
// One atom is handled at a time. Advance-pass and measure-pass atoms are
// both paced by the shared one-bit-per-cycle 80-bit divider that each
// component uses in turn. The last measure atom adds two divisions and two
// 32-step square roots; the second root is skipped when the error is zero.
// Zero-mass atoms do not wait for the divider. A finished result is held
// in the output register while the next atom may be accepted once it has
// been taken.
module variable_step_verlet_update_core #(
  parameter int MAX_ATOMS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsvu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vsvu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import vsvu_pkg::*;

  localparam int CntW = $clog2(MAX_ATOMS + 1);

  logic [31:0] accuracy;
  logic [31:0] max_step_size;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy <= 32'd4294967;
      max_step_size <= 32'd17179869;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCURACY: accuracy <= cfg_data;
        CFG_MAX_STEP: max_step_size <= cfg_data;
        default: ;
      endcase
    end
  end

  vsvu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  vsvu_datapath #(.CntW(CntW), .MaxAtoms(MAX_ATOMS)) u_dp (
    .clk, .rst, .item(in_data), .cmd, .accuracy, .max_step_size, .status,
    .result(out_data)
  );

endmodule

>>> design/vsvu_checker.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module vsvu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input vsvu_pkg::out_item_t out_data
);
  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");

  // An accepted atom is worked on alone.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second item taken");

  // No result can appear right after acceptance.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid) else $error("early result");
endmodule

bind variable_step_verlet_update_core vsvu_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

>>> dv/variable_step_verlet_update_core_tb.sv
// ----------------------------------------------------------------------------
// Variable-step Verlet update core testbench
// Streams measure and advance passes of atoms through the core under several
// accuracy and step-limit settings, with random bursts on the input side and
// random stalls on the output side. Every output transaction is checked field
// by field against a fixed-point step and atom-update predictor.
// ----------------------------------------------------------------------------
module variable_step_verlet_update_core_tb;
  import vsvu_pkg::*;

  localparam int ATOM_LIMIT  = 65536;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 700;
  localparam logic [31:0] ACC_RESET  = 32'd4294967;
  localparam logic [31:0] MAXS_RESET = 32'd17179869;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  variable_step_verlet_update_core #(.MAX_ATOMS(ATOM_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and configuration copy.
  logic [31:0] acc_reg, max_step_reg, cur_step, vel_interval;
  logic [63:0] err_accum;
  int          atoms_seen;

  in_item_t  pending_atoms[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  bit        hold_tx = 1'b0;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] sat_word(longint v);
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  // floor(sqrt(acc * 2^48 / err)), saturated to 32 bits.
  function automatic logic [31:0] step_from_error(logic [31:0] acc, logic [31:0] err);
    logic [63:0] d, q, rem, t;
    d = {32'd0, err};
    q = acc / d;
    rem = acc % d;
    if (q >= 64'h10000) return 32'hFFFF_FFFF;
    for (int i = 0; i < 3; i++) begin
      t = rem << 16;
      q = (q << 16) | (t / d);
      rem = t % d;
    end
    return 32'(isqrt64(q));
  endfunction

  // Work out the result, if any, for one accepted atom transaction.
  task automatic predict_atom(input in_item_t it);
    logic signed [31:0] px[3], vx[3], fx[3];
    logic [63:0] m, a, s, mean, old_step, nw, dv, dx;
    logic [31:0] err;
    longint      vn, vv, xn;
    out_item_t   res;
    px = '{it.pos_x, it.pos_y, it.pos_z};
    vx = '{it.vel_x, it.vel_y, it.vel_z};
    fx = '{it.force_x, it.force_y, it.force_z};
    m = {32'd0, it.mass};
    res = '0;
    if (it.req_type == 1'b0) begin
      for (int j = 0; j < 3; j++) begin
        if (m != 0) begin
          a = (magnitude(longint'(fx[j])) << 16) / m;
          if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
          s = err_accum + a * a;
          err_accum = (s < err_accum) ? '1 : s;
        end
      end
      if (atoms_seen < ATOM_LIMIT) atoms_seen++;
      if (it.last_atom) begin
        mean = err_accum / (64'd3 * 64'(atoms_seen));
        err = 32'(isqrt64(mean));
        old_step = {32'd0, cur_step};
        nw = (err == 0) ? 64'hFFFF_FFFF : {32'd0, step_from_error(acc_reg, err)};
        if (old_step > 0 && nw > 2 * old_step) nw = 2 * old_step;
        if (nw > old_step && 5 * nw < 6 * old_step) nw = old_step;
        if (nw > {32'd0, max_step_reg}) nw = {32'd0, max_step_reg};
        vel_interval = 32'((nw + old_step) >> 1);
        cur_step = nw[31:0];
        err_accum = 0;
        atoms_seen = 0;
        res.step_out = nw[31:0];
        expected_results.push_back(res);
      end
    end else begin
      logic signed [31:0] npos[3], nvel[3];
      for (int j = 0; j < 3; j++) begin
        if (m == 0) begin
          npos[j] = px[j];
          nvel[j] = vx[j];
        end else begin
          dv = (magnitude(longint'(fx[j])) * {32'd0, vel_interval}) / (m << 16);
          vn = (fx[j] < 0) ? longint'(vx[j]) - longint'(dv) : longint'(vx[j]) + longint'(dv);
          nvel[j] = sat_word(vn);
          vv = longint'(nvel[j]);
          dx = (magnitude(vv) * {32'd0, cur_step}) >> 32;
          xn = (vv < 0) ? longint'(px[j]) - longint'(dx) : longint'(px[j]) + longint'(dx);
          npos[j] = sat_word(xn);
        end
      end
      res.result_kind = 1'b1;
      res.step_out = cur_step;
      res.new_pos_x = npos[0];
      res.new_pos_y = npos[1];
      res.new_pos_z = npos[2];
      res.new_vel_x = nvel[0];
      res.new_vel_y = nvel[1];
      res.new_vel_z = nvel[2];
      expected_results.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
             results_checked);
    error_count++;
  endtask

  // Input driver: bursts of transactions with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_atom(in_data);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_atoms.size() > 0 && !hold_tx) begin
          in_data <= pending_atoms.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern, with its style chosen anew whenever its timer runs out.
  int stall_mode = 0;
  int stall_timer = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_timer = $urandom_range(200, 800);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Output monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, step_out", out_data.step_out, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_kind !== want.result_kind)
          report_mismatch("result_kind", 32'(out_data.result_kind), 32'(want.result_kind));
        if (out_data.step_out !== want.step_out)
          report_mismatch("step_out", out_data.step_out, want.step_out);
        if (out_data.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", out_data.new_pos_x, want.new_pos_x);
        if (out_data.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", out_data.new_pos_y, want.new_pos_y);
        if (out_data.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", out_data.new_pos_z, want.new_pos_z);
        if (out_data.new_vel_x !== want.new_vel_x)
          report_mismatch("new_vel_x", out_data.new_vel_x, want.new_vel_x);
        if (out_data.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", out_data.new_vel_y, want.new_vel_y);
        if (out_data.new_vel_z !== want.new_vel_z)
          report_mismatch("new_vel_z", out_data.new_vel_z, want.new_vel_z);
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0003_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1;
      3: return $urandom;
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  function automatic in_item_t make_atom(logic rt, logic last);
    in_item_t it;
    it.req_type = rt;
    it.last_atom = last;
    it.mass = rand_mass();
    it.pos_x = rand_word();
    it.pos_y = rand_word();
    it.pos_z = rand_word();
    it.vel_x = rand_word();
    it.vel_y = rand_word();
    it.vel_z = rand_word();
    it.force_x = rand_word();
    it.force_y = rand_word();
    it.force_z = rand_word();
    return it;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ACCURACY) acc_reg = val;
    else max_step_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until the core has finished all work, including silent measure atoms.
  task automatic wait_idle();
    while (pending_atoms.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly complete measure/advance pass pairs with random atoms, some noise.
  task automatic queue_random(input int count);
    int n, queued;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_atoms.push_back(make_atom($urandom_range(0, 1), $urandom_range(0, 1)));
        queued++;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          pending_atoms.push_back(make_atom(1'b0, i == n - 1));
        for (int i = 0; i < n; i++)
          pending_atoms.push_back(make_atom(1'b1, $urandom_range(0, 3) == 0));
        queued += 2 * n;
      end
    end
  endtask

  initial begin
    in_item_t it;
    acc_reg = ACC_RESET;
    max_step_reg = MAXS_RESET;
    cur_step = 0;
    vel_interval = 0;
    err_accum = 0;
    atoms_seen = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: advance before any measure, with zero and nonzero mass.
    pending_atoms.push_back(make_atom(1'b1, 1'b0));
    it = make_atom(1'b1, 1'b1);
    it.mass = 0;
    pending_atoms.push_back(it);
    // Zero-mass measure pass gives zero error, so the raw step saturates before the limits.
    it = make_atom(1'b0, 1'b1);
    it.mass = 0;
    pending_atoms.push_back(it);
    // Extreme forces on a tiny-mass non-last atom, then on a huge-mass last one.
    it = make_atom(1'b0, 1'b0);
    it.mass = 32'h1;
    it.force_x = 32'sh7FFF_FFFF;
    it.force_y = 32'sh8000_0000;
    it.force_z = 32'sh0;
    pending_atoms.push_back(it);
    it.mass = 32'hFFFF_FFFF;
    it.last_atom = 1'b1;
    pending_atoms.push_back(it);
    // Advance atoms that drive the saturation of velocity and position.
    it = make_atom(1'b1, 1'b0);
    it.mass = 32'h1;
    it.pos_x = 32'sh7FFF_FFFF;
    it.vel_x = 32'sh7FFF_FFFF;
    it.force_x = 32'sh7FFF_FFFF;
    it.pos_y = 32'sh8000_0000;
    it.vel_y = 32'sh8000_0000;
    it.force_y = 32'sh8000_0000;
    pending_atoms.push_back(it);
    it.mass = 32'hFFFF_FFFF;
    it.last_atom = 1'b1;
    pending_atoms.push_back(it);
    // Repeated small measure passes exercise growth and hold limits.
    for (int k = 0; k < 4; k++) begin
      pending_atoms.push_back(make_atom(1'b0, 1'b1));
      pending_atoms.push_back(make_atom(1'b1, 1'b0));
    end
    wait_idle();

    // Largest accuracy and step limit.
    write_reg(CFG_ACCURACY, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_STEP, 32'hFFFF_FFFF);
    queue_random(250);
    wait_idle();

    // Smallest nonzero settings.
    write_reg(CFG_ACCURACY, 32'h1);
    write_reg(CFG_MAX_STEP, 32'h1);
    queue_random(120);
    wait_idle();

    // Zero step limit: atoms keep their positions.
    write_reg(CFG_MAX_STEP, 32'h0);
    queue_random(50);
    wait_idle();

    // Random settings, with a pause in the middle until all results are in.
    write_reg(CFG_ACCURACY, $urandom);
    write_reg(CFG_MAX_STEP, $urandom);
    queue_random(150);
    while (pending_atoms.size() > 100) @(posedge clk);
    hold_tx = 1'b1;
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    hold_tx = 1'b0;
    wait_idle();

    // Reset-value settings with random streams.
    write_reg(CFG_ACCURACY, ACC_RESET);
    write_reg(CFG_MAX_STEP, MAXS_RESET);
    queue_random(400);
    wait_idle();

    $display("Ran %0d atom transactions across reset, extreme, zero-step and",
             items_sent);
    $display("random register settings; %0d results checked.", results_checked);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/vsvu_pkg.sv
design/vsvu_datapath.sv
design/vsvu_ctrl.sv
design/variable_step_verlet_update_core.sv
design/vsvu_checker.sv
dv/variable_step_verlet_update_core_tb.sv
